// ----- rtl/gbc_pkg.sv -----
// Shared types and constants for the gammatone biquad cascade.
package gbc_pkg;

   localparam int WORD_BITS      = 48;
   localparam int STATE_FRAC     = 16;
   localparam int COEF_BITS      = 32;
   localparam int HALF_BITS      = 24;
   localparam int MUL_BITS       = COEF_BITS + HALF_BITS + 1;
   localparam int CROSS_COUNT    = 4;
   localparam int CSR_INDEX_BITS = 3;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [COEF_BITS-1:0] coef_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_FIRST_FEED  = 3'd0,
      REG_LATER_FEED  = 3'd1,
      REG_STAGE0_CROSS = 3'd2,
      REG_STAGE1_CROSS = 3'd3,
      REG_STAGE2_CROSS = 3'd4,
      REG_STAGE3_CROSS = 3'd5,
      REG_POLE_FIRST  = 3'd6,
      REG_POLE_SECOND = 3'd7
   } csr_reg_type;

   typedef enum logic [1:0] {
      COEF_B0,
      COEF_B1,
      COEF_A1,
      COEF_A2
   } coef_sel_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_RUN,
      CS_FINISH
   } ctrl_state_type;

   // Micro-steps of one biquad stage.
   typedef enum logic [3:0] {
      ST_B0_LO,
      ST_B0_HI,
      ST_B1_LO,
      ST_B1_HI,
      ST_Y_UPD,
      ST_A1_LO,
      ST_A1_HI,
      ST_A2_LO,
      ST_A2_HI,
      ST_D0_UPD,
      ST_A2_RND,
      ST_D1_UPD
   } step_type;

   typedef struct packed {
      coef_sel_type coef_sel;
      logic         use_y;
      logic         hi_half;
      logic         acc_load;
      logic         acc_add;
      logic         rnd_en;
      logic         y_upd;
      logic         part_save;
      logic         d0_upd;
      logic         d1_upd;
      logic         load_in;
      logic         out_load;
   } dp_cmd_type;

endpackage

// ----- rtl/gammatone_biquad_cascade.sv -----
// Top level of one gammatone channel built from a cascade of biquad stages, four by default.
//
//   Channel   Direction  Handshake                Payload
//   req_      in         req_tvalid / req_tready  tdata: sample_in; tlast: block_end_in
//   rsp_      out        rsp_tvalid / rsp_tready  tdata: sample_out; tlast: block_end_out
//   csr_      in         csr_valid / csr_ready    csr_index, csr_data (one register word)
//
// A new word is accepted only after the previous one has been through every stage.
// All products go through the single shared 32 x 25 multiplier:
// every stage needs four coefficient products of a 48-bit operand, and each product
// takes two passes through the multiplier, one per operand half.
// Reset clears the coefficient registers and all delay words to zero at once.
// A new input word is accepted while the previous result still waits in the output
// register; a finished result only stalls the sequencer if that register is still full.
module gammatone_biquad_cascade #(
   parameter int STAGE_COUNT   = 4,
   parameter int SAMPLE_BITS   = 24,
   parameter int COEF_FRACTION = 30
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [SAMPLE_BITS-1:0] sample_in, zero padded to whole bytes
   input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [SAMPLE_BITS-1:0] sample_out, zero padded to whole bytes
   output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gbc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [gbc_pkg::COEF_BITS-1:0]       csr_data
);
   import gbc_pkg::*;

   localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int STG_W  = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;

   dp_cmd_type                    cmd;
   logic [STG_W-1:0]              stage;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          csr_write;

   // Configuration always ready; software must write only while channel is idle, unchecked.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   gbc_ctrl #(
      .STAGE_COUNT (STAGE_COUNT),
      .STG_W       (STG_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stage      (stage)
   );

   gbc_datapath #(
      .STAGE_COUNT   (STAGE_COUNT),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .COEF_FRACTION (COEF_FRACTION),
      .STG_W         (STG_W)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stage         (stage),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .sample_in     ($signed(req_tdata[SAMPLE_BITS-1:0])),
      .block_end_in  (req_tlast),
      .sample_out    (sample_out),
      .block_end_out (rsp_tlast)
   );

   // The sample sits in the low bits; the pad bits above it are zero.
   assign rsp_tdata = DATA_W'($unsigned(sample_out));

endmodule

// ----- rtl/gbc_ctrl.sv -----
// Sequencer that walks every sample through the stages of the cascade.
module gbc_ctrl #(
   parameter int STAGE_COUNT = 4,
   parameter int STG_W       = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output gbc_pkg::dp_cmd_type cmd,
   output logic [STG_W-1:0]    stage
);
   import gbc_pkg::*;

   localparam logic [STG_W-1:0] LAST_STAGE = STG_W'(STAGE_COUNT - 1);

   ctrl_state_type   state_ff, state_in;
   step_type         step_ff, step_in;
   logic [STG_W-1:0] stage_ff, stage_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state and counters.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      stage_in = stage_ff;
      case (state_ff)
         CS_IDLE: begin
            step_in  = ST_B0_LO;
            stage_in = '0;
            if (req_tvalid) begin
               state_in = CS_RUN;
            end
         end
         CS_RUN: begin
            if (step_ff == ST_D1_UPD) begin
               step_in  = ST_B0_LO;
               stage_in = STG_W'(stage_ff + 1'b1);
               if (stage_ff == LAST_STAGE) begin
                  state_in = CS_FINISH;
               end
            end else begin
               step_in = step_type'(step_ff + 4'd1);
            end
         end
         CS_FINISH: begin
            if (out_free) begin
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         CS_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = req_tvalid;
         end
         CS_RUN: begin
            case (step_ff)
               ST_B0_LO: begin
                  cmd.coef_sel = COEF_B0;
               end
               ST_B0_HI: begin
                  cmd.coef_sel = COEF_B0;
                  cmd.hi_half  = 1'b1;
                  cmd.acc_load = 1'b1;
               end
               ST_B1_LO: begin
                  cmd.coef_sel = COEF_B1;
                  cmd.acc_add  = 1'b1;
               end
               ST_B1_HI: begin
                  cmd.coef_sel = COEF_B1;
                  cmd.hi_half  = 1'b1;
                  cmd.acc_load = 1'b1;
                  cmd.rnd_en   = 1'b1;
               end
               ST_Y_UPD: begin
                  cmd.acc_add = 1'b1;
                  cmd.y_upd   = 1'b1;
               end
               ST_A1_LO: begin
                  cmd.coef_sel = COEF_A1;
                  cmd.use_y    = 1'b1;
                  cmd.rnd_en   = 1'b1;
               end
               ST_A1_HI: begin
                  cmd.coef_sel  = COEF_A1;
                  cmd.use_y     = 1'b1;
                  cmd.hi_half   = 1'b1;
                  cmd.acc_load  = 1'b1;
                  cmd.part_save = 1'b1;
               end
               ST_A2_LO: begin
                  cmd.coef_sel = COEF_A2;
                  cmd.use_y    = 1'b1;
                  cmd.acc_add  = 1'b1;
               end
               ST_A2_HI: begin
                  cmd.coef_sel = COEF_A2;
                  cmd.use_y    = 1'b1;
                  cmd.hi_half  = 1'b1;
                  cmd.acc_load = 1'b1;
                  cmd.rnd_en   = 1'b1;
               end
               ST_D0_UPD: begin
                  cmd.acc_add = 1'b1;
                  cmd.d0_upd  = 1'b1;
               end
               ST_A2_RND: begin
                  cmd.rnd_en = 1'b1;
               end
               ST_D1_UPD: begin
                  cmd.d1_upd = 1'b1;
               end
               default: begin
                  cmd = '0;
               end
            endcase
         end
         CS_FINISH: begin
            cmd.out_load = out_free;
            if (out_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         step_ff      <= ST_B0_LO;
         stage_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         stage_ff     <= stage_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign stage      = stage_ff;

endmodule

// ----- rtl/gbc_datapath.sv -----
// Coefficient registers, shared multiplier, accumulator and delay words of the cascade.
module gbc_datapath #(
   parameter int STAGE_COUNT   = 4,
   parameter int SAMPLE_BITS   = 24,
   parameter int COEF_FRACTION = 30,
   parameter int STG_W         = 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gbc_pkg::dp_cmd_type                   cmd,
   input  logic [STG_W-1:0]                      stage,
   input  logic                                  csr_write,
   input  logic [gbc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [gbc_pkg::COEF_BITS-1:0]         csr_data,
   input  logic signed [SAMPLE_BITS-1:0]         sample_in,
   input  logic                                  block_end_in,
   output logic signed [SAMPLE_BITS-1:0]         sample_out,
   output logic                                  block_end_out
);
   import gbc_pkg::*;

   localparam int ACC_W = COEF_BITS + WORD_BITS + 1;
   localparam int SUM_W = WORD_BITS + 2;
   localparam int OUT_W = WORD_BITS + 1 - STATE_FRAC;
   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRACTION - 1);
   localparam logic signed [WORD_BITS:0] OUT_HALF = (WORD_BITS + 1)'(1) << (STATE_FRAC - 1);
   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

   // Saturate a sum of up to three words back to the word range.
   function automatic word_type sat_sum(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-WORD_BITS:0] top;
      top = v[SUM_W-1:WORD_BITS-1];
      if (top == '0 || top == '1) begin
         return v[WORD_BITS-1:0];
      end else if (v[SUM_W-1]) begin
         return WORD_MIN;
      end else begin
         return WORD_MAX;
      end
   endfunction

   // Configuration registers.
   coef_type first_feed_ff, later_feed_ff, pole1_ff, pole2_ff;
   coef_type cross_ff [CROSS_COUNT];

   // Working registers.
   word_type                    x_ff, y_ff, term_ff, part_ff;
   word_type                    d0_ff [STAGE_COUNT];
   word_type                    d1_ff [STAGE_COUNT];
   logic signed [MUL_BITS-1:0]  mul_ff;
   logic signed [ACC_W-1:0]     acc_ff;
   logic signed [SAMPLE_BITS-1:0] out_ff;
   logic                        last_ff, out_last_ff;

   logic [STG_W+1:0]            stage_wide;
   logic [1:0]                  cross_idx;
   coef_type                    coef;
   word_type                    operand;
   logic signed [HALF_BITS:0]   half;
   logic signed [MUL_BITS-1:0]  mul_in;
   logic signed [ACC_W-1:0]     rnd_sum, rnd_shift;
   logic [ACC_W-WORD_BITS:0]    rnd_top;
   word_type                    term_in;
   logic signed [WORD_BITS:0]   out_sum;
   logic signed [OUT_W-1:0]     out_shift;
   logic [OUT_W-SAMPLE_BITS:0]  out_top;
   logic signed [SAMPLE_BITS-1:0] out_in;
   word_type                    y_in, d0_in, d1_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_feed_ff <= '0;
         later_feed_ff <= '0;
         pole1_ff      <= '0;
         pole2_ff      <= '0;
         for (int i = 0; i < CROSS_COUNT; i++) begin
            cross_ff[i] <= '0;
         end
      end else if (csr_write) begin
         case (csr_index)
            REG_FIRST_FEED:   first_feed_ff <= csr_data;
            REG_LATER_FEED:   later_feed_ff <= csr_data;
            REG_STAGE0_CROSS: cross_ff[0]   <= csr_data;
            REG_STAGE1_CROSS: cross_ff[1]   <= csr_data;
            REG_STAGE2_CROSS: cross_ff[2]   <= csr_data;
            REG_STAGE3_CROSS: cross_ff[3]   <= csr_data;
            REG_POLE_FIRST:   pole1_ff      <= csr_data;
            REG_POLE_SECOND:  pole2_ff      <= csr_data;
            default:          pole2_ff      <= pole2_ff;
         endcase
      end
   end

   // Stages past the fourth reuse the four cross-term registers in rotation.
   assign stage_wide = {2'b00, stage};
   assign cross_idx  = stage_wide[1:0];

   always_comb begin
      case (cmd.coef_sel)
         COEF_B0: coef = (stage == '0) ? first_feed_ff : later_feed_ff;
         COEF_B1: coef = cross_ff[cross_idx];
         COEF_A1: coef = pole1_ff;
         COEF_A2: coef = pole2_ff;
         default: coef = '0;
      endcase
   end

   // A 48-bit operand is split into a signed upper half and an unsigned lower half.
   assign operand = cmd.use_y ? y_ff : x_ff;
   assign half    = cmd.hi_half ? $signed({operand[WORD_BITS-1], operand[WORD_BITS-1:HALF_BITS]})
                                : $signed({1'b0, operand[HALF_BITS-1:0]});
   assign mul_in  = MUL_BITS'(coef) * MUL_BITS'(half);

   // Round half up at the coefficient point, then saturate.
   assign rnd_sum   = acc_ff + RND_HALF;
   assign rnd_shift = rnd_sum >>> COEF_FRACTION;
   assign rnd_top   = rnd_shift[ACC_W-1:WORD_BITS-1];
   always_comb begin
      if (rnd_top == '0 || rnd_top == '1) begin
         term_in = rnd_shift[WORD_BITS-1:0];
      end else if (rnd_shift[ACC_W-1]) begin
         term_in = WORD_MIN;
      end else begin
         term_in = WORD_MAX;
      end
   end

   assign y_in  = sat_sum(SUM_W'(term_ff) + SUM_W'(d0_ff[stage]));
   assign d0_in = sat_sum(SUM_W'(part_ff) - SUM_W'(term_ff) + SUM_W'(d1_ff[stage]));
   assign d1_in = sat_sum(-SUM_W'(term_ff));

   // Final rounding from the state scale to the sample scale.
   assign out_sum   = (WORD_BITS + 1)'(x_ff) + OUT_HALF;
   assign out_shift = OUT_W'(out_sum >>> STATE_FRAC);
   assign out_top   = out_shift[OUT_W-1:SAMPLE_BITS-1];
   always_comb begin
      if (out_top == '0 || out_top == '1) begin
         out_in = out_shift[SAMPLE_BITS-1:0];
      end else if (out_shift[OUT_W-1]) begin
         out_in = SMP_MIN;
      end else begin
         out_in = SMP_MAX;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
      if (cmd.acc_load) begin
         acc_ff <= ACC_W'(mul_ff);
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + (ACC_W'(mul_ff) <<< HALF_BITS);
      end
      if (cmd.rnd_en) begin
         term_ff <= term_in;
      end
      if (cmd.part_save) begin
         part_ff <= term_ff;
      end
      if (cmd.y_upd) begin
         y_ff <= y_in;
      end
      if (cmd.load_in) begin
         x_ff    <= WORD_BITS'(sample_in) <<< STATE_FRAC;
         last_ff <= block_end_in;
      end else if (cmd.d1_upd) begin
         x_ff <= y_ff;
      end
      if (cmd.out_load) begin
         out_ff      <= out_in;
         out_last_ff <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGE_COUNT; i++) begin
            d0_ff[i] <= '0;
            d1_ff[i] <= '0;
         end
      end else begin
         if (cmd.d0_upd) begin
            d0_ff[stage] <= d0_in;
         end
         if (cmd.d1_upd) begin
            d1_ff[stage] <= d1_in;
         end
      end
   end

   assign sample_out    = out_ff;
   assign block_end_out = out_last_ff;

endmodule
